// ----- design/g2dc_pkg.sv -----
// Shared constants, types and tables for the Gaussian conic and tile bounds pipeline.
package g2dc_pkg;

    // Default module parameters
    localparam int TILE_SIZE_DEF = 16;
    localparam int MAX_DIM_DEF   = 4096;

    // Field widths
    localparam int POS_W    = 16;
    localparam int SIGMA_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int CFG_W    = 16;
    localparam int DIM_W    = 13;
    localparam int RF_W     = 16;
    localparam int CENTER_W = 21;
    localparam int CONIC_W  = 32;
    localparam int BOX_W    = 13;
    localparam int TILE_W   = 9;

    // Configuration register indexes
    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_RADIUS_FACTOR = 2'd2;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST   = 13'd1024;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST  = 13'd1024;
    localparam logic [RF_W-1:0]  RADIUS_FACTOR_RST = 16'd12288;

    // Angle folding, Q.16
    localparam int FOLD_W = 22;
    localparam logic signed [FOLD_W-1:0] PI_Q16      = 22'sd205887;
    localparam logic signed [FOLD_W-1:0] TWO_PI_Q16  = 22'sd411775;
    localparam logic signed [FOLD_W-1:0] HALF_PI_Q16 = 22'sd102944;

    // CORDIC
    localparam int CORDIC_STEPS = 16;
    localparam int XW           = 20;
    localparam int ZW           = 20;
    localparam int TRIG_W       = 18;
    localparam logic signed [XW-1:0] CORDIC_K_Q16 = 20'sd39797;
    localparam logic signed [XW-1:0] ONE_Q16      = 20'sd65536;
    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
        20'sd16, 20'sd8, 20'sd4, 20'sd2
    };

    // Radius divider: numerator is radius_factor * 256 + min - 1
    localparam int NUM_W     = RF_W + 8 + 1;
    localparam int DIV_STEPS = NUM_W;

    // Pipeline stage numbers (stage 1 is the input register)
    localparam int CORDIC_AT = 1 + CORDIC_STEPS + 1;
    localparam int CONIC_AT  = CORDIC_AT + 3;
    localparam int DIV_AT    = 1 + DIV_STEPS;
    localparam int LAT       = DIV_AT + 2;

    typedef struct packed {
        logic        [CONIC_W-1:0] xx;
        logic signed [CONIC_W-1:0] xy;
        logic        [CONIC_W-1:0] yy;
    } conic_t;

endpackage

// ----- design/g2dc_in_if.sv -----
// Input channel: one Gaussian per transaction.
interface g2dc_in_if;
    logic                        valid;
    logic                        ready;
    logic        [15:0]          pos_x;
    logic        [15:0]          pos_y;
    logic        [15:0]          inv_sigma_x;
    logic        [15:0]          inv_sigma_y;
    logic signed [15:0]          angle;

    modport source (output valid, pos_x, pos_y, inv_sigma_x, inv_sigma_y, angle,
                    input ready);
    modport sink (input valid, pos_x, pos_y, inv_sigma_x, inv_sigma_y, angle,
                  output ready);
endinterface

// ----- design/g2dc_out_if.sv -----
// Output channel: conic and bounds of one Gaussian per transaction.
interface g2dc_out_if;
    logic                 valid;
    logic                 ready;
    logic        [20:0]   center_x;
    logic        [20:0]   center_y;
    logic        [31:0]   conic_xx;
    logic signed [31:0]   conic_xy;
    logic        [31:0]   conic_yy;
    logic        [12:0]   box_x_start;
    logic        [12:0]   box_y_start;
    logic        [12:0]   box_x_end;
    logic        [12:0]   box_y_end;
    logic        [8:0]    tile_x_end;
    logic        [8:0]    tile_y_end;

    modport source (output valid, center_x, center_y, conic_xx, conic_xy, conic_yy,
                    box_x_start, box_y_start, box_x_end, box_y_end,
                    tile_x_end, tile_y_end,
                    input ready);
    modport sink (input valid, center_x, center_y, conic_xx, conic_xy, conic_yy,
                  box_x_start, box_y_start, box_x_end, box_y_end,
                  tile_x_end, tile_y_end,
                  output ready);
endinterface

// ----- design/g2dc_cordic.sv -----
// Pipelined CORDIC: one rotation step per stage, then saturation and sign fix.
module g2dc_cordic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [g2dc_pkg::ZW-1:0]      angle_z,
    input  logic                                neg,
    output logic signed [g2dc_pkg::TRIG_W-1:0]  cos_q,
    output logic signed [g2dc_pkg::TRIG_W-1:0]  sin_q
);
    import g2dc_pkg::*;

    logic signed [TRIG_W-1:0] cos_reg;
    logic signed [TRIG_W-1:0] sin_reg;
    logic signed [XW-1:0]     x_sat;
    logic signed [XW-1:0]     y_sat;
    logic signed [TRIG_W-1:0] cos_next;
    logic signed [TRIG_W-1:0] sin_next;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [ZW-1:0] zi;
        logic                 ni;
        logic signed [XW-1:0] x_reg;
        logic signed [XW-1:0] y_reg;
        logic signed [ZW-1:0] z_reg;
        logic                 neg_reg;

        if (i == 0) begin : g_first
            assign xi = CORDIC_K_Q16;
            assign yi = '0;
            assign zi = angle_z;
            assign ni = neg;
        end else begin : g_rest
            assign xi = g_iter[i-1].x_reg;
            assign yi = g_iter[i-1].y_reg;
            assign zi = g_iter[i-1].z_reg;
            assign ni = g_iter[i-1].neg_reg;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (zi >= 0)
                begin
                    x_reg <= xi - (yi >>> i);
                    y_reg <= yi + (xi >>> i);
                    z_reg <= zi - ATAN_TAB[i];
                end
                else
                begin
                    x_reg <= xi + (yi >>> i);
                    y_reg <= yi - (xi >>> i);
                    z_reg <= zi + ATAN_TAB[i];
                end
                neg_reg <= ni;
            end
        end
    end

    always_comb
    begin
        x_sat = g_iter[CORDIC_STEPS-1].x_reg;
        y_sat = g_iter[CORDIC_STEPS-1].y_reg;
        if (x_sat > ONE_Q16)
            x_sat = ONE_Q16;
        else if (x_sat < -ONE_Q16)
            x_sat = -ONE_Q16;
        if (y_sat > ONE_Q16)
            y_sat = ONE_Q16;
        else if (y_sat < -ONE_Q16)
            y_sat = -ONE_Q16;
        // fold back the half-turn removed before rotation
        if (g_iter[CORDIC_STEPS-1].neg_reg)
        begin
            x_sat = -x_sat;
            y_sat = -y_sat;
        end
        cos_next = TRIG_W'(x_sat);
        sin_next = TRIG_W'(y_sat);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

// ----- design/g2dc_conic.sv -----
// Conic terms from sine, cosine and the inverse std-devs, three stages.
module g2dc_conic (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [g2dc_pkg::TRIG_W-1:0]  cos_q,
    input  logic signed [g2dc_pkg::TRIG_W-1:0]  sin_q,
    input  logic        [g2dc_pkg::SIGMA_W-1:0] u,
    input  logic        [g2dc_pkg::SIGMA_W-1:0] v,
    output g2dc_pkg::conic_t                    conic
);
    import g2dc_pkg::*;

    localparam int SQ_W  = 2 * SIGMA_W;
    localparam int T2_W  = TRIG_W - 1;
    localparam int P_W   = SQ_W + T2_W;
    localparam int PE_W  = SQ_W + 1 + TRIG_W;

    logic signed [2*TRIG_W-1:0] cc_prod;
    logic signed [2*TRIG_W-1:0] ss_prod;
    logic signed [2*TRIG_W-1:0] sc_prod;
    logic        [SQ_W-1:0]     u_sq;
    logic        [SQ_W-1:0]     v_sq;

    // first stage: squares
    logic        [T2_W-1:0]   co2_reg;
    logic        [T2_W-1:0]   si2_reg;
    logic signed [TRIG_W-1:0] sc_reg;
    logic        [SQ_W-1:0]   u2_reg;
    logic        [SQ_W-1:0]   v2_reg;
    logic signed [SQ_W:0]     dif_reg;

    // second stage: products
    logic        [P_W-1:0]    pa_reg;
    logic        [P_W-1:0]    pb_reg;
    logic        [P_W-1:0]    pc_reg;
    logic        [P_W-1:0]    pd_reg;
    logic signed [PE_W-1:0]   pe_reg;

    logic        [P_W:0]      sum_xx;
    logic        [P_W:0]      sum_yy;
    conic_t                   conic_reg;
    conic_t                   conic_next;

    assign cc_prod = cos_q * cos_q;
    assign ss_prod = sin_q * sin_q;
    assign sc_prod = sin_q * cos_q;
    assign u_sq    = u * u;
    assign v_sq    = v * v;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            co2_reg <= T2_W'(cc_prod >>> 16);
            si2_reg <= T2_W'(ss_prod >>> 16);
            sc_reg  <= TRIG_W'(sc_prod >>> 16);
            u2_reg  <= u_sq;
            v2_reg  <= v_sq;
            dif_reg <= (SQ_W+1)'(u_sq) - (SQ_W+1)'(v_sq);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= u2_reg * co2_reg;
            pb_reg <= v2_reg * si2_reg;
            pc_reg <= u2_reg * si2_reg;
            pd_reg <= v2_reg * co2_reg;
            pe_reg <= dif_reg * sc_reg;
        end
    end

    always_comb
    begin
        sum_xx = (P_W+1)'(pa_reg) + (P_W+1)'(pb_reg);
        sum_yy = (P_W+1)'(pc_reg) + (P_W+1)'(pd_reg);
        conic_next.xx = CONIC_W'(sum_xx >> 24);
        conic_next.yy = CONIC_W'(sum_yy >> 24);
        conic_next.xy = CONIC_W'(pe_reg >>> 24);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            conic_reg <= conic_next;
    end

    assign conic = conic_reg;

endmodule

// ----- design/g2dc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
module g2dc_div (
    input  logic                               clk,
    input  logic                               en,
    input  logic [g2dc_pkg::NUM_W-1:0]         num,
    input  logic [g2dc_pkg::SIGMA_W-1:0]       den,
    output logic [g2dc_pkg::NUM_W-1:0]         quo
);
    import g2dc_pkg::*;

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int BIT = NUM_W - 1 - j;
        logic [SIGMA_W-1:0] ri;
        logic [NUM_W-1:0]   ni;
        logic [SIGMA_W-1:0] di;
        logic [NUM_W-1:0]   qi;
        logic [SIGMA_W:0]   trial;
        logic               ge;
        logic [SIGMA_W-1:0] rem_next;
        logic [NUM_W-1:0]   quo_next;
        logic [SIGMA_W-1:0] rem_reg;
        logic [NUM_W-1:0]   num_reg;
        logic [SIGMA_W-1:0] den_reg;
        logic [NUM_W-1:0]   quo_reg;

        if (j == 0) begin : g_first
            assign ri = '0;
            assign ni = num;
            assign di = den;
            assign qi = '0;
        end else begin : g_rest
            assign ri = g_step[j-1].rem_reg;
            assign ni = g_step[j-1].num_reg;
            assign di = g_step[j-1].den_reg;
            assign qi = g_step[j-1].quo_reg;
        end

        always_comb
        begin
            trial = {ri, ni[BIT]};
            ge = (trial >= {1'b0, di});
            rem_next = ge ? SIGMA_W'(trial - {1'b0, di}) : SIGMA_W'(trial);
            quo_next = qi;
            quo_next[BIT] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                num_reg <= ni;
                den_reg <= di;
                quo_reg <= quo_next;
            end
        end
    end

    assign quo = g_step[DIV_STEPS-1].quo_reg;

endmodule

// ----- design/g2dc_bounds.sv -----
// Pixel box from centre and radius, clamped to the image, then end tile indices.
module g2dc_bounds #(
    parameter int TILE_SIZE = g2dc_pkg::TILE_SIZE_DEF,
    parameter int DW        = 13,
    parameter int CXW       = 21
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [CXW-1:0]              cx,
    input  logic [CXW-1:0]              cy,
    input  logic [g2dc_pkg::NUM_W-1:0]  radius,
    input  logic [DW-1:0]               w,
    input  logic [DW-1:0]               h,
    output logic [CXW-1:0]              center_x,
    output logic [CXW-1:0]              center_y,
    output logic [DW-1:0]               x_start,
    output logic [DW-1:0]               y_start,
    output logic [DW-1:0]               x_end,
    output logic [DW-1:0]               y_end,
    output logic [DW-1:0]               tx_end,
    output logic [DW-1:0]               ty_end
);
    import g2dc_pkg::*;

    localparam int SW = ((CXW > NUM_W) ? CXW : NUM_W) + 2;
    localparam int TL = $clog2(TILE_SIZE);
    localparam int SH = DW + TL;
    localparam logic [SH:0] RECIP =
        (SH+1)'(((longint'(1) << SH) + TILE_SIZE - 1) / TILE_SIZE);

    function automatic logic [DW-1:0] lo_edge(input logic [CXW-1:0] c,
                                              input logic [NUM_W-1:0] r,
                                              input logic [DW-1:0] lim);
        logic signed [SW-1:0] d;
        logic signed [SW-1:0] dp;
        logic        [DW-1:0] res;
        d = SW'(c) - SW'(r);
        dp = d >>> 8;
        if (d[SW-1])
            res = '0;
        else if (dp > SW'(lim))
            res = lim;
        else
            res = DW'(dp);
        return res;
    endfunction

    function automatic logic [DW-1:0] hi_edge(input logic [CXW-1:0] c,
                                              input logic [NUM_W-1:0] r,
                                              input logic [DW-1:0] lim);
        logic [SW-1:0] s;
        logic [SW-1:0] sp;
        logic [DW-1:0] res;
        s = SW'(c) + SW'(r) + SW'(255);
        sp = (s >> 8) + SW'(1);
        if (sp > SW'(lim))
            res = lim;
        else
            res = DW'(sp);
        return res;
    endfunction

    // floor(x / TILE_SIZE) by reciprocal, exact for every DW-bit x
    function automatic logic [DW-1:0] tdiv(input logic [DW-1:0] x);
        logic [DW+SH:0] p;
        p = x * RECIP;
        return DW'(p >> SH);
    endfunction

    logic [CXW-1:0] cx_reg, cy_reg;
    logic [DW-1:0]  x0_reg, x1_reg, y0_reg, y1_reg;
    logic [CXW-1:0] center_x_reg, center_y_reg;
    logic [DW-1:0]  x_start_reg, y_start_reg, x_end_reg, y_end_reg;
    logic [DW-1:0]  tx_end_reg, ty_end_reg;
    logic           empty;
    logic [DW-1:0]  tx_end_next, ty_end_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg <= cx;
            cy_reg <= cy;
            x0_reg <= lo_edge(cx, radius, w);
            x1_reg <= hi_edge(cx, radius, w);
            y0_reg <= lo_edge(cy, radius, h);
            y1_reg <= hi_edge(cy, radius, h);
        end
    end

    always_comb
    begin
        empty = (x0_reg >= x1_reg) || (y0_reg >= y1_reg);
        // an empty box ends where it starts
        if (empty)
        begin
            tx_end_next = tdiv(x0_reg);
            ty_end_next = tdiv(y0_reg);
        end
        else
        begin
            tx_end_next = tdiv(DW'(x1_reg - 1'b1)) + DW'(1);
            ty_end_next = tdiv(DW'(y1_reg - 1'b1)) + DW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            center_x_reg <= cx_reg;
            center_y_reg <= cy_reg;
            x_start_reg  <= x0_reg;
            y_start_reg  <= y0_reg;
            x_end_reg    <= x1_reg;
            y_end_reg    <= y1_reg;
            tx_end_reg   <= tx_end_next;
            ty_end_reg   <= ty_end_next;
        end
    end

    assign center_x = center_x_reg;
    assign center_y = center_y_reg;
    assign x_start  = x_start_reg;
    assign y_start  = y_start_reg;
    assign x_end    = x_end_reg;
    assign y_end    = y_end_reg;
    assign tx_end   = tx_end_reg;
    assign ty_end   = ty_end_reg;

endmodule

// ----- design/gaussian_2d_conic_and_tile_bounds.sv -----
// Gaussian splat set-up: a fixed pipeline of 28 register stages that takes one
// Gaussian per cycle while the output is not stalled and returns its pixel
// centre, conic (inverse covariance), clamped pixel box and end tile indices.
// Depth is set by the radius divider, which resolves one of its 25 quotient bits
// per stage; sine and cosine come from a 16-stage CORDIC running beside it. The
// whole pipeline advances together whenever the output register is empty or being
// taken, so a stalled output holds every stage. Configuration writes take effect
// at once; the user must make them only while the pipeline is empty (unchecked).
module gaussian_2d_conic_and_tile_bounds #(
    parameter int TILE_SIZE = g2dc_pkg::TILE_SIZE_DEF,
    parameter int MAX_DIM   = g2dc_pkg::MAX_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    g2dc_in_if.sink                      in_ch,
    g2dc_out_if.source                   out_ch,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [g2dc_pkg::CFG_W-1:0]   cfg_data
);
    import g2dc_pkg::*;

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int CXW = POS_W + DW - 8;

    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic [RF_W-1:0]  radius_factor_reg;
    logic [DW-1:0]    w_eff, h_eff;

    logic             en;
    logic             vld_reg [1:LAT];

    // input stage
    logic [POS_W+DW-1:0]      px_prod, py_prod;
    logic [SIGMA_W-1:0]       u_c, v_c, m_c;
    logic signed [FOLD_W-1:0] th0, th1, th2;
    logic                     neg_next;
    logic signed [ZW-1:0]     th_reg;
    logic                     neg_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [SIGMA_W-1:0]       m_reg;

    logic [SIGMA_W-1:0]       u_dly_reg [1:CORDIC_AT];
    logic [SIGMA_W-1:0]       v_dly_reg [1:CORDIC_AT];
    logic [CXW-1:0]           cx_dly_reg [1:DIV_AT];
    logic [CXW-1:0]           cy_dly_reg [1:DIV_AT];
    conic_t                   conic_dly_reg [CONIC_AT+1:LAT];

    logic signed [TRIG_W-1:0] cos_q, sin_q;
    conic_t                   conic;
    logic [NUM_W-1:0]         radius;

    logic [CXW-1:0] center_x, center_y;
    logic [DW-1:0]  x_start, y_start, x_end, y_end, tx_end, ty_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= IMAGE_WIDTH_RST;
            image_height_reg  <= IMAGE_HEIGHT_RST;
            radius_factor_reg <= RADIUS_FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   image_width_reg   <= DIM_W'(cfg_data);
                CFG_IMAGE_HEIGHT:  image_height_reg  <= DIM_W'(cfg_data);
                CFG_RADIUS_FACTOR: radius_factor_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff = (image_width_reg > MAX_DIM) ? DW'(MAX_DIM) : DW'(image_width_reg);
    assign h_eff = (image_height_reg > MAX_DIM) ? DW'(MAX_DIM) : DW'(image_height_reg);

    // advance the whole pipeline unless the output is held
    assign en = !vld_reg[LAT] || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_ch.valid;
            for (int k = 2; k <= LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_comb
    begin
        px_prod = in_ch.pos_x * w_eff;
        py_prod = in_ch.pos_y * h_eff;
        u_c = (in_ch.inv_sigma_x == '0) ? SIGMA_W'(1) : in_ch.inv_sigma_x;
        v_c = (in_ch.inv_sigma_y == '0) ? SIGMA_W'(1) : in_ch.inv_sigma_y;
        m_c = (u_c < v_c) ? u_c : v_c;
        th0 = {{(FOLD_W-ANGLE_W-4){in_ch.angle[ANGLE_W-1]}}, in_ch.angle, 4'b0000};
        if (th0 > PI_Q16)
            th1 = th0 - TWO_PI_Q16;
        else if (th0 < -PI_Q16)
            th1 = th0 + TWO_PI_Q16;
        else
            th1 = th0;
        // bring into the right half-plane; the rotation result is negated later
        if (th1 > HALF_PI_Q16)
        begin
            th2 = th1 - PI_Q16;
            neg_next = 1'b1;
        end
        else if (th1 < -HALF_PI_Q16)
        begin
            th2 = th1 + PI_Q16;
            neg_next = 1'b1;
        end
        else
        begin
            th2 = th1;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th_reg        <= ZW'(th2);
            neg_reg       <= neg_next;
            num_reg       <= NUM_W'({radius_factor_reg, 8'h00}) + NUM_W'(m_c) - NUM_W'(1);
            m_reg         <= m_c;
            u_dly_reg[1]  <= u_c;
            v_dly_reg[1]  <= v_c;
            cx_dly_reg[1] <= px_prod[POS_W+DW-1:8];
            cy_dly_reg[1] <= py_prod[POS_W+DW-1:8];
            for (int k = 2; k <= CORDIC_AT; k++)
            begin
                u_dly_reg[k] <= u_dly_reg[k-1];
                v_dly_reg[k] <= v_dly_reg[k-1];
            end
            for (int k = 2; k <= DIV_AT; k++)
            begin
                cx_dly_reg[k] <= cx_dly_reg[k-1];
                cy_dly_reg[k] <= cy_dly_reg[k-1];
            end
            conic_dly_reg[CONIC_AT+1] <= conic;
            for (int k = CONIC_AT + 2; k <= LAT; k++)
                conic_dly_reg[k] <= conic_dly_reg[k-1];
        end
    end

    g2dc_cordic u_cordic (
        .clk     (clk),
        .en      (en),
        .angle_z (th_reg),
        .neg     (neg_reg),
        .cos_q   (cos_q),
        .sin_q   (sin_q)
    );

    g2dc_conic u_conic (
        .clk   (clk),
        .en    (en),
        .cos_q (cos_q),
        .sin_q (sin_q),
        .u     (u_dly_reg[CORDIC_AT]),
        .v     (v_dly_reg[CORDIC_AT]),
        .conic (conic)
    );

    g2dc_div u_div (
        .clk (clk),
        .en  (en),
        .num (num_reg),
        .den (m_reg),
        .quo (radius)
    );

    g2dc_bounds #(
        .TILE_SIZE (TILE_SIZE),
        .DW        (DW),
        .CXW       (CXW)
    ) u_bounds (
        .clk      (clk),
        .en       (en),
        .cx       (cx_dly_reg[DIV_AT]),
        .cy       (cy_dly_reg[DIV_AT]),
        .radius   (radius),
        .w        (w_eff),
        .h        (h_eff),
        .center_x (center_x),
        .center_y (center_y),
        .x_start  (x_start),
        .y_start  (y_start),
        .x_end    (x_end),
        .y_end    (y_end),
        .tx_end   (tx_end),
        .ty_end   (ty_end)
    );

    assign out_ch.valid       = vld_reg[LAT];
    assign out_ch.center_x    = CENTER_W'(center_x);
    assign out_ch.center_y    = CENTER_W'(center_y);
    assign out_ch.conic_xx    = conic_dly_reg[LAT].xx;
    assign out_ch.conic_xy    = conic_dly_reg[LAT].xy;
    assign out_ch.conic_yy    = conic_dly_reg[LAT].yy;
    assign out_ch.box_x_start = BOX_W'(x_start);
    assign out_ch.box_y_start = BOX_W'(y_start);
    assign out_ch.box_x_end   = BOX_W'(x_end);
    assign out_ch.box_y_end   = BOX_W'(y_end);
    assign out_ch.tile_x_end  = TILE_W'(tx_end);
    assign out_ch.tile_y_end  = TILE_W'(ty_end);

endmodule
